// ----- hdl/stps_pkg.sv -----
// package for the sorted table position search block
// holds codes, item and state types shared by the interfaces and modules
// no dependencies
package stps_pkg;

    // default table depth and queue depth
    localparam int TABLE_DEPTH_DEF = 256;
    localparam int QUEUE_DEPTH     = 2;

    // fixed field widths
    localparam int KIND_W  = 2;
    localparam int INDEX_W = 8;
    localparam int KEY_W   = 32;
    localparam int COUNT_W = 9;
    localparam int POS_W   = 8;

    // input kind codes
    localparam logic [KIND_W-1:0] KIND_WRITE        = 2'd0;
    localparam logic [KIND_W-1:0] KIND_QUERY_FIRST  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY_SECOND = 2'd2;
    localparam logic [KIND_W-1:0] KIND_UNUSED       = 2'd3;

    // register word index
    localparam logic REG_ENTRY_COUNT = 1'b0;

    // reset value of entry count
    localparam logic [COUNT_W-1:0] ENTRY_COUNT_RST = 9'd1;

    // classified operation carried through the queue
    typedef enum logic [1:0] {
        OP_WRITE,
        OP_QUERY_FIRST,
        OP_QUERY_SECOND
    } t_op;

    typedef struct packed {
        t_op                op;
        logic               in_range;
        logic [INDEX_W-1:0] entry_index;
        logic [KEY_W-1:0]   first_key;
        logic [KEY_W-1:0]   second_key;
        logic [KEY_W-1:0]   target;
    } t_item;

    // back end sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_DONE
    } t_state;

endpackage

// ----- hdl/stps_if.sv -----
// valid/ready channel interfaces for input items and result items
// depends on stps_pkg
interface stps_in_if;
    import stps_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        kind;
    logic [INDEX_W-1:0]       entry_index;
    logic signed [KEY_W-1:0]  first_key;
    logic signed [KEY_W-1:0]  second_key;
    logic signed [KEY_W-1:0]  target;

    modport source (output valid, kind, entry_index, first_key, second_key, target,
                    input ready);
    modport sink (input valid, kind, entry_index, first_key, second_key, target,
                  output ready);
endinterface

interface stps_out_if;
    import stps_pkg::*;

    logic             valid;
    logic             ready;
    logic [POS_W-1:0] position;

    modport source (output valid, position, input ready);
    modport sink (input valid, position, output ready);
endinterface

// ----- hdl/stps_front.sv -----
// front end: takes input beats, classifies the kind and range-checks writes
// depends on stps_pkg and stps_in_if; pushes into stps_queue
module stps_front #(
    parameter int TABLE_DEPTH = stps_pkg::TABLE_DEPTH_DEF
) (
    stps_in_if.sink          i_in,
    input  logic             i_q_full,
    output logic             o_push,
    output stps_pkg::t_item  o_item
);
    import stps_pkg::*;

    logic [31:0] idx_ext;
    logic        keep;

    // accept whenever the queue has room
    assign i_in.ready = ~i_q_full;
    assign idx_ext    = {{(32-INDEX_W){1'b0}}, i_in.entry_index};

    // classify the beat, unused kind is swallowed
    always_comb begin
        keep        = 1'b1;
        o_item.op   = OP_WRITE;
        unique case (i_in.kind)
            KIND_WRITE:        o_item.op = OP_WRITE;
            KIND_QUERY_FIRST:  o_item.op = OP_QUERY_FIRST;
            KIND_QUERY_SECOND: o_item.op = OP_QUERY_SECOND;
            KIND_UNUSED:       keep = 1'b0;
            default:           keep = 1'b0;
        endcase
        o_item.in_range    = (idx_ext < 32'(TABLE_DEPTH));
        o_item.entry_index = i_in.entry_index;
        o_item.first_key   = i_in.first_key;
        o_item.second_key  = i_in.second_key;
        o_item.target      = i_in.target;
    end

    assign o_push = i_in.valid & ~i_q_full & keep;

endmodule

// ----- hdl/stps_queue.sv -----
// short fifo between the front end and the search sequencer
// depends on stps_pkg
module stps_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  stps_pkg::t_item  i_item,
    output logic             o_full,
    output logic             o_valid,
    output stps_pkg::t_item  o_item,
    input  logic             i_pop
);
    import stps_pkg::*;

    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_item          r_slot [QUEUE_DEPTH];
    logic [QW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [QW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]  r_count, n_count;
    logic           do_push, do_pop;

    assign o_full  = (r_count == CW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_slot[r_rd_ptr];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & o_valid;

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == QW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == QW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // slot storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ----- hdl/stps_back.sv -----
// back end: key table memory, binary search sequencer and result register
// depends on stps_pkg and stps_out_if; pops from stps_queue
module stps_back #(
    parameter int TABLE_DEPTH = stps_pkg::TABLE_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [$clog2(TABLE_DEPTH+1)-1:0]    i_entry_count,
    input  logic                                i_q_valid,
    input  stps_pkg::t_item                     i_q_item,
    output logic                                o_q_pop,
    stps_out_if.source                          o_out
);
    import stps_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // both keys of an entry side by side, second key in the upper half
    logic [2*KEY_W-1:0]      r_mem [TABLE_DEPTH];
    logic [2*KEY_W-1:0]      r_rd;

    t_state                  r_state, n_state;
    logic [CW-1:0]           r_lo, n_lo;
    logic [CW-1:0]           r_hi, n_hi;
    logic                    r_col, n_col;
    logic signed [KEY_W-1:0] r_target, n_target;
    logic [POS_W-1:0]        r_res, n_res;
    logic                    r_out_valid, n_out_valid;
    logic [POS_W-1:0]        r_pos, n_pos;

    logic signed [KEY_W-1:0] key;
    logic                    hit;
    logic [CW:0]             mid_sum;
    logic [CW-1:0]           mid;
    logic [CW-1:0]           last;
    logic [31:0]             idx_ext;
    logic [31:0]             last_ext;
    logic [AW-1:0]           rd_addr;
    logic                    wr_en;

    assign key     = r_col ? signed'(r_rd[2*KEY_W-1:KEY_W]) : signed'(r_rd[KEY_W-1:0]);
    assign hit     = r_col ? (key > r_target) : (key >= r_target);
    assign idx_ext = {{(32-INDEX_W){1'b0}}, i_q_item.entry_index};
    assign last    = (r_lo == i_entry_count) ? i_entry_count - 1'b1 : r_lo;
    assign last_ext = 32'(last);

    // sequencer: one probe per cycle, new bounds pick the next read address
    always_comb begin
        n_state     = r_state;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_col       = r_col;
        n_target    = r_target;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_pos       = r_pos;
        o_q_pop     = 1'b0;
        wr_en       = 1'b0;
        mid_sum     = '0;
        mid         = '0;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                mid = i_entry_count >> 1;
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    if (i_q_item.op == OP_WRITE) begin
                        wr_en = i_q_item.in_range;
                    end else begin
                        n_lo     = '0;
                        n_hi     = i_entry_count;
                        n_col    = (i_q_item.op == OP_QUERY_SECOND);
                        n_target = signed'(i_q_item.target);
                        n_state  = S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                if (r_lo < r_hi) begin
                    mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
                    mid     = mid_sum[CW:1];
                    if (hit) begin
                        n_hi = mid;
                    end else begin
                        n_lo = mid + 1'b1;
                    end
                    mid_sum = {1'b0, n_lo} + {1'b0, n_hi};
                    mid     = mid_sum[CW:1];
                end else begin
                    n_res   = last_ext[POS_W-1:0];
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_pos       = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        rd_addr = mid[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // search bounds and result payload
    always_ff @(posedge i_clk) begin
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_col    <= n_col;
        r_target <= n_target;
        r_res    <= n_res;
        r_pos    <= n_pos;
    end

    // key table, one write port and one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[idx_ext[AW-1:0]] <= {i_q_item.second_key, i_q_item.first_key};
        end
        r_rd <= r_mem[rd_addr];
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.position = r_pos;

endmodule

// ----- hdl/sorted_table_position_search.sv -----
// sorted table position search: write items fill a two-key table, query items
// return a clamped lower bound (first key) or upper bound (second key) position.
// a query is searched once it reaches the head of the queue, one key read per step;
// its result is then registered and waits in S_DONE until the output register is free
// throughput: one write per cycle while the sequencer is idle; a query search holds writes back
// reset: entry count returns to 1, queue and result register empty; table not cleared
module sorted_table_position_search #(
    parameter int TABLE_DEPTH = stps_pkg::TABLE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    stps_in_if.sink                       i_in,
    stps_out_if.source                    o_out,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [2:0]                    i_paddr,
    input  logic [31:0]                   i_pwdata,
    output logic [31:0]                   o_prdata,
    output logic                          o_pready
);
    import stps_pkg::*;

    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [COUNT_W-1:0] r_count;
    logic [31:0]        count_ext;
    logic [31:0]        eff_ext;
    logic [CW-1:0]      eff_count;
    logic               reg_wr;
    logic               q_full;
    logic               q_push;
    t_item              q_in_item;
    logic               q_valid;
    t_item              q_out_item;
    logic               q_pop;

    // configuration register beat
    assign o_pready = 1'b1;
    assign reg_wr   = i_psel & i_penable & i_pwrite & (i_paddr[2] == REG_ENTRY_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= ENTRY_COUNT_RST;
        end else if (reg_wr) begin
            r_count <= i_pwdata[COUNT_W-1:0];
        end
    end

    assign o_prdata = (i_paddr[2] == REG_ENTRY_COUNT) ? {{(32-COUNT_W){1'b0}}, r_count} : '0;

    // effective count clamped to 1 .. depth
    assign count_ext = {{(32-COUNT_W){1'b0}}, r_count};
    always_comb begin
        priority if (count_ext == '0) begin
            eff_ext = 32'd1;
        end else if (count_ext > 32'(TABLE_DEPTH)) begin
            eff_ext = 32'(TABLE_DEPTH);
        end else begin
            eff_ext = count_ext;
        end
    end
    assign eff_count = eff_ext[CW-1:0];

    stps_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_item   (q_in_item)
    );

    stps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in_item),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_out_item),
        .i_pop   (q_pop)
    );

    stps_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_entry_count (eff_count),
        .i_q_valid     (q_valid),
        .i_q_item      (q_out_item),
        .o_q_pop       (q_pop),
        .o_out         (o_out)
    );

endmodule
